FILE: design/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants of the median-of-five sigma detector.
// ----------------------------------------------------------------------------
package msd_pkg;

	localparam int MaxRowSamples = 65536;
	localparam int SampleBits    = 24;
	localparam int RmsBits       = 23;
	localparam int ThrBits       = 16;
	localparam int StartDmBits   = 24;
	localparam int DmStepBits    = 16;
	localparam int IdxBits       = 16;
	localparam int DmBits        = 32;
	localparam int CfgIdxBits    = 2;
	localparam int CfgDataBits   = 24;

	localparam logic [CfgIdxBits-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CfgIdxBits-1:0] REG_START_DM  = 2'd1;
	localparam logic [CfgIdxBits-1:0] REG_DM_STEP   = 2'd2;
	localparam logic [CfgIdxBits-1:0] REG_SNR_MODE  = 2'd3;

	localparam logic [ThrBits-1:0]     THRESHOLD_RESET = 16'd1280;
	localparam logic [StartDmBits-1:0] START_DM_RESET  = 24'd0;
	localparam logic [DmStepBits-1:0]  DM_STEP_RESET   = 16'd256;
	localparam logic [DmBits-1:0]      DM_MIN          = 32'd256;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_OUTPUT
	} msd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;      // accept an input transaction
		logic div_start; // load the divider
		logic div_step;  // one quotient bit
		logic out_load;  // move the result to the output register
	} msd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;       // the accepted sample produced a detection
		logic div_done;  // last quotient bit taken
	} msd_status_t;

endpackage

FILE: design/msd_ctrl.sv
// ----------------------------------------------------------------------------
// msd_ctrl
// Controller: accepts samples and sequences the significance divider.
// ----------------------------------------------------------------------------
module msd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_busy,
	input  msd_pkg::msd_status_t status,
	output msd_pkg::msd_cmd_t    cmd
);
	import msd_pkg::*;

	msd_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && status.hit) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_done) state_d = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				if (!out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				cmd.div_start = in_valid && status.hit;
			end
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_OUTPUT: cmd.out_load = !out_busy;
			default: ;
		endcase
	end
endmodule

FILE: design/msd_datapath.sv
// ----------------------------------------------------------------------------
// msd_datapath
// Window, median, threshold test, row counters, divider and output register.
// ----------------------------------------------------------------------------
module msd_datapath #(
	parameter int MAX_ROW_SAMPLES = msd_pkg::MaxRowSamples,
	parameter int SAMPLE_BITS     = msd_pkg::SampleBits
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  msd_pkg::msd_cmd_t                  cmd,
	output msd_pkg::msd_status_t               status,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	input  logic signed [SAMPLE_BITS-1:0]      noise_mean,
	input  logic [msd_pkg::RmsBits-1:0]        noise_rms,
	input  logic                               first_row,
	input  logic                               row_end,
	input  logic [msd_pkg::ThrBits-1:0]        threshold,
	input  logic [msd_pkg::StartDmBits-1:0]    start_dm,
	input  logic [msd_pkg::DmStepBits-1:0]     dm_step,
	input  logic                               snr_mode,
	input  logic                               out_taken,
	output logic                               out_valid,
	output logic [msd_pkg::IdxBits-1:0]        sample_index,
	output logic [msd_pkg::IdxBits-1:0]        row_index,
	output logic [msd_pkg::DmBits-1:0]         dm_value,
	output logic signed [SAMPLE_BITS-1:0]      median_value,
	output logic signed [SAMPLE_BITS-1:0]      significance
);
	import msd_pkg::*;

	localparam int PosBits = $clog2(MAX_ROW_SAMPLES + 1);
	localparam int NumBits = SAMPLE_BITS + 10;           // (diff or median) * 256
	localparam int QBits   = NumBits;
	localparam int CntBits = $clog2(QBits + 1);
	localparam int DBits   = RmsBits + 1;
	localparam logic signed [SAMPLE_BITS-1:0] SatHi = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SatLo = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] win_s_q [4];
	logic signed [SAMPLE_BITS-1:0] win_m_q [4];
	logic [RmsBits-1:0]            win_r_q [4];
	logic [2:0]                    fill_q;
	logic [PosBits-1:0]            pos_q;
	logic [IdxBits-1:0]            row_q;
	logic [DmBits-1:0]             dm_q;

	// Effective state after a block start.
	logic [2:0]         fill_e;
	logic [PosBits-1:0] pos_e;
	logic [IdxBits-1:0] row_e;
	logic [DmBits-1:0]  dm_e;
	logic               active, full;

	assign fill_e = first_row ? 3'd0 : fill_q;
	assign pos_e  = first_row ? '0 : pos_q;
	assign row_e  = first_row ? '0 : row_q;
	assign dm_e   = first_row ? DmBits'(start_dm) : dm_q;
	assign active = pos_e < PosBits'(MAX_ROW_SAMPLES);
	assign full   = fill_e == 3'd4;

	// Median of five by counting, for each element, how many fall below it.
	logic signed [SAMPLE_BITS-1:0] w [5];
	logic signed [SAMPLE_BITS-1:0] med;
	always_comb begin
		logic [2:0] lt, eq;
		for (int i = 0; i < 4; i++) w[i] = first_row ? '0 : win_s_q[i];
		w[4] = sample;
		med = w[0];
		for (int i = 0; i < 5; i++) begin
			lt = '0;
			eq = '0;
			for (int j = 0; j < 5; j++) begin
				if (w[j] < w[i]) lt = lt + 3'd1;
				else if (w[j] == w[i]) eq = eq + 3'd1;
			end
			if (lt <= 3'd2 && (lt + eq) > 3'd2) med = w[i];
		end
	end

	// Threshold test: (median - mean) * 256 >= rms * threshold.
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [SAMPLE_BITS+8:0] lhs;
	logic [RmsBits+ThrBits-1:0]    rhs;
	logic                          pass;
	assign diff = (SAMPLE_BITS+1)'(med) - (SAMPLE_BITS+1)'(win_m_q[0]);
	assign lhs  = {diff, 8'd0};
	assign rhs  = (RmsBits+ThrBits)'(win_r_q[0]) * (RmsBits+ThrBits)'(threshold);
	assign pass = lhs >= $signed({1'b0, rhs});
	assign status.hit = active && full && pass && (dm_e > DM_MIN);

	// Window, position, row and DM registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			row_q  <= '0;
			dm_q   <= DmBits'(START_DM_RESET);
			for (int i = 0; i < 4; i++) begin
				win_s_q[i] <= '0;
				win_m_q[i] <= '0;
				win_r_q[i] <= '0;
			end
		end else if (cmd.take) begin
			if (active) begin
				if (!full) begin
					win_s_q[fill_e[1:0]] <= sample;
					win_m_q[fill_e[1:0]] <= noise_mean;
					win_r_q[fill_e[1:0]] <= noise_rms;
					fill_q <= fill_e + 3'd1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						win_s_q[i] <= win_s_q[i+1];
						win_m_q[i] <= win_m_q[i+1];
						win_r_q[i] <= win_r_q[i+1];
					end
					win_s_q[3] <= sample;
					win_m_q[3] <= noise_mean;
					win_r_q[3] <= noise_rms;
					fill_q <= fill_e;
				end
				pos_q <= pos_e + PosBits'(1);
			end else begin
				fill_q <= fill_e;
				pos_q  <= pos_e;
			end
			row_q <= row_e;
			dm_q  <= dm_e;
			if (row_end) begin
				fill_q <= '0;
				pos_q  <= '0;
				row_q  <= row_e + IdxBits'(1);
				dm_q   <= ({1'b0, dm_e} + (DmBits+1)'(dm_step)) > (DmBits+1)'({DmBits{1'b1}})
					? {DmBits{1'b1}} : DmBits'(dm_e + DmBits'(dm_step));
			end
		end
	end

	// Restoring divider on magnitudes, one quotient bit per cycle.
	logic [DBits-1:0]        rem_q;
	logic [QBits-1:0]        quo_q;
	logic [DBits-1:0]        den_q;
	logic [CntBits-1:0]      cnt_q;
	logic                    neg_q, zero_q, numz_q;
	logic [IdxBits-1:0]      idx_q, rowh_q;
	logic [DmBits-1:0]       dmh_q;
	logic signed [SAMPLE_BITS-1:0] med_q;
	logic signed [NumBits-1:0] num;
	logic [QBits-1:0]        mag;
	logic [DBits:0]          trial;
	logic [DBits:0]          part;

	assign num = snr_mode ? NumBits'(lhs) : NumBits'($signed({med, 8'd0}));
	assign mag = num[NumBits-1] ? QBits'(-num) : QBits'(num);
	assign part  = {rem_q, quo_q[QBits-1]};
	assign trial = part - {1'b0, den_q};
	assign status.div_done = cnt_q == CntBits'(1);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= mag;
			den_q  <= DBits'(win_r_q[0]);
			cnt_q  <= CntBits'(QBits);
			neg_q  <= num[NumBits-1];
			zero_q <= win_r_q[0] == '0;
			numz_q <= mag == '0;
			idx_q  <= IdxBits'(pos_e - PosBits'(4));
			rowh_q <= row_e;
			dmh_q  <= dm_e;
			med_q  <= med;
		end else if (cmd.div_step) begin
			if (!trial[DBits]) begin
				rem_q <= trial[DBits-1:0];
				quo_q <= {quo_q[QBits-2:0], 1'b1};
			end else begin
				rem_q <= part[DBits-1:0];
				quo_q <= {quo_q[QBits-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CntBits'(1);
		end
	end

	// Saturated signed quotient; a zero rms saturates by the numerator's sign, or gives zero for a zero numerator.
	logic signed [SAMPLE_BITS-1:0] sig;
	always_comb begin
		if (zero_q) begin
			sig = numz_q ? '0 : (neg_q ? SatLo : SatHi);
		end else if (quo_q > QBits'(SatHi)) begin
			sig = neg_q ? SatLo : SatHi;
		end else begin
			sig = neg_q ? SAMPLE_BITS'(-quo_q) : SAMPLE_BITS'(quo_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_taken) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_index <= idx_q;
			row_index    <= rowh_q;
			dm_value     <= dmh_q;
			median_value <= med_q;
			significance <= sig;
		end
	end
endmodule

FILE: design/median_sigma_detector_unit.sv
// ----------------------------------------------------------------------------
// median_sigma_detector_unit
// Median-of-five threshold detector over dedispersed sample rows.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel with their chunk noise mean and rms;
// first_row and row_end travel in s_axis_tuser. Detections leave on m_axis.
// Registers are to be written on the cfg channel (index, data) only while idle;
// the block itself does not enforce this. A sample that causes no detection
// does not hold the input. A detection holds the input for the significance
// divider: one quotient bit per cycle over SAMPLE_BITS+10 bits, then the
// result moves into the output register. While the receiver stalls with a
// result held, samples still flow; a second detection waits in the controller
// until the output register frees. Reset restores register defaults, clears
// the window and counters, and leaves the output empty.
// ----------------------------------------------------------------------------
module median_sigma_detector_unit #(
	parameter int MAX_ROW_SAMPLES = msd_pkg::MaxRowSamples,
	parameter int SAMPLE_BITS     = msd_pkg::SampleBits
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sample, noise_mean, noise_rms, zero fill
	input  logic [((2*SAMPLE_BITS+msd_pkg::RmsBits+7)/8)*8-1:0] s_axis_tdata,
	// first_row, row_end
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// sample_index, row_index, dm_value, median_value, significance, zero fill
	output logic [((64+2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [msd_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [msd_pkg::CfgDataBits-1:0] cfg_data
);
	import msd_pkg::*;

	localparam int OutW = ((64+2*SAMPLE_BITS+7)/8)*8;

	logic [ThrBits-1:0]     thr_q;
	logic [StartDmBits-1:0] sdm_q;
	logic [DmStepBits-1:0]  step_q;
	logic                   mode_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THRESHOLD_RESET;
			sdm_q  <= START_DM_RESET;
			step_q <= DM_STEP_RESET;
			mode_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q  <= cfg_data[ThrBits-1:0];
				REG_START_DM:  sdm_q  <= cfg_data[StartDmBits-1:0];
				REG_DM_STEP:   step_q <= cfg_data[DmStepBits-1:0];
				REG_SNR_MODE:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	msd_cmd_t    cmd;
	msd_status_t status;
	logic [IdxBits-1:0] o_idx, o_row;
	logic [DmBits-1:0]  o_dm;
	logic signed [SAMPLE_BITS-1:0] o_med, o_sig;
	logic out_busy;

	assign out_busy = m_axis_tvalid && !m_axis_tready;

	msd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_busy (out_busy),
		.status   (status),
		.cmd      (cmd)
	);

	msd_datapath #(
		.MAX_ROW_SAMPLES (MAX_ROW_SAMPLES),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
		.noise_mean   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.noise_rms    (s_axis_tdata[2*SAMPLE_BITS+RmsBits-1:2*SAMPLE_BITS]),
		.first_row    (s_axis_tuser[0]),
		.row_end      (s_axis_tuser[1]),
		.threshold    (thr_q),
		.start_dm     (sdm_q),
		.dm_step      (step_q),
		.snr_mode     (mode_q),
		.out_taken    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.sample_index (o_idx),
		.row_index    (o_row),
		.dm_value     (o_dm),
		.median_value (o_med),
		.significance (o_sig)
	);

	assign m_axis_tdata = OutW'({o_sig, o_med, o_dm, o_row, o_idx});
endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the median-of-five sigma detector. Sample rows with
// random noise statistics and occasional pulses are streamed in. A scoreboard
// predicts every detection from the accepted samples and compares each
// detection leaving the block field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import msd_pkg::*;

	localparam int InW  = ((2*SampleBits+RmsBits+7)/8)*8;
	localparam int OutW = ((64+2*SampleBits+7)/8)*8;
	localparam int Watchdog = 20000;

	// One predicted detection.
	typedef struct packed {
		logic [IdxBits-1:0]    sample_index;
		logic [IdxBits-1:0]    row_index;
		logic [DmBits-1:0]     dm_value;
		logic [SampleBits-1:0] median_value;
		logic [SampleBits-1:0] significance;
	} detection_t;

	// Predicts detections from accepted samples and checks the block's output.
	class detection_scoreboard;
		logic [ThrBits-1:0]     threshold;
		logic [StartDmBits-1:0] start_dm;
		logic [DmStepBits-1:0]  dm_step;
		logic                   snr_mode;
		longint win_smp[4];
		longint win_mean[4];
		longint win_rms[4];
		int unsigned fill;
		int unsigned pos;
		int unsigned row;
		longint unsigned cur_dm;
		detection_t pending[$];
		int errors;

		function void reset_state();
			threshold = THRESHOLD_RESET;
			start_dm = START_DM_RESET;
			dm_step = DM_STEP_RESET;
			snr_mode = 1'b1;
			clear_window();
			row = 0;
			cur_dm = 0;
			errors = 0;
		endfunction

		function void clear_window();
			for (int i = 0; i < 4; i++) begin
				win_smp[i] = 0;
				win_mean[i] = 0;
				win_rms[i] = 0;
			end
			fill = 0;
			pos = 0;
		endfunction

		function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
			case (idx)
				REG_THRESHOLD: threshold = val[ThrBits-1:0];
				REG_START_DM:  start_dm = val[StartDmBits-1:0];
				REG_DM_STEP:   dm_step = val[DmStepBits-1:0];
				REG_SNR_MODE:  snr_mode = val[0];
				default: ;
			endcase
		endfunction

		function longint saturate(longint v);
			longint hi;
			hi = (longint'(1) <<< (SampleBits-1)) - 1;
			if (v > hi) return hi;
			if (v < -hi-1) return -hi-1;
			return v;
		endfunction

		// Notes one accepted sample and queues the detection it causes, if any.
		function void note_sample(logic [InW-1:0] data, logic [1:0] user);
			longint smp, mn, rms, med, diff, num, sig, tmp;
			longint s[5];
			detection_t d;
			smp = longint'($signed(data[SampleBits-1:0]));
			mn = longint'($signed(data[2*SampleBits-1:SampleBits]));
			rms = longint'(data[2*SampleBits+RmsBits-1:2*SampleBits]);
			if (user[0]) begin
				clear_window();
				row = 0;
				cur_dm = start_dm;
			end
			if (pos < MaxRowSamples) begin
				if (fill < 4) begin
					win_smp[fill] = smp;
					win_mean[fill] = mn;
					win_rms[fill] = rms;
					fill++;
				end else begin
					for (int i = 0; i < 4; i++) s[i] = win_smp[i];
					s[4] = smp;
					// Sort five values; the middle one is the median.
					for (int i = 0; i < 5; i++)
						for (int j = 0; j < 4 - i; j++)
							if (s[j] > s[j+1]) begin
								tmp = s[j];
								s[j] = s[j+1];
								s[j+1] = tmp;
							end
					med = s[2];
					diff = med - win_mean[0];
					if (diff * 256 >= win_rms[0] * longint'(threshold) && cur_dm > 256) begin
						num = (snr_mode ? diff : med) * 256;
						if (win_rms[0] == 0)
							sig = (num > 0) ? saturate(64'sh7fffffffffffffff)
								: (num < 0 ? saturate(-64'sh7fffffffffffffff - 1) : 0);
						else
							sig = saturate(num / win_rms[0]);
						d.sample_index = IdxBits'(pos - 4);
						d.row_index = IdxBits'(row);
						d.dm_value = DmBits'(cur_dm);
						d.median_value = SampleBits'(med);
						d.significance = SampleBits'(sig);
						pending.push_back(d);
					end
					for (int i = 0; i < 3; i++) begin
						win_smp[i] = win_smp[i+1];
						win_mean[i] = win_mean[i+1];
						win_rms[i] = win_rms[i+1];
					end
					win_smp[3] = smp;
					win_mean[3] = mn;
					win_rms[3] = rms;
				end
				pos++;
			end
			if (user[1]) begin
				clear_window();
				row = (row + 1) & 16'hffff;
				cur_dm = cur_dm + dm_step;
				if (cur_dm > 64'hffffffff) cur_dm = 64'hffffffff;
			end
		endfunction

		// Compares one detection leaving the block with the oldest prediction.
		function void check_detection(logic [OutW-1:0] data);
			detection_t got, want;
			got.sample_index = data[15:0];
			got.row_index = data[31:16];
			got.dm_value = data[63:32];
			got.median_value = data[64+SampleBits-1:64];
			got.significance = data[64+2*SampleBits-1:64+SampleBits];
			if (pending.size() == 0) begin
				$display("%0t: unexpected detection %h", $realtime, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.sample_index != want.sample_index)
				$display("%0t: sample_index expected %0d actual %0d", $realtime,
					want.sample_index, got.sample_index);
			if (got.row_index != want.row_index)
				$display("%0t: row_index expected %0d actual %0d", $realtime,
					want.row_index, got.row_index);
			if (got.dm_value != want.dm_value)
				$display("%0t: dm_value expected %0d actual %0d", $realtime,
					want.dm_value, got.dm_value);
			if (got.median_value != want.median_value)
				$display("%0t: median_value expected %h actual %h", $realtime,
					want.median_value, got.median_value);
			if (got.significance != want.significance)
				$display("%0t: significance expected %h actual %h", $realtime,
					want.significance, got.significance);
			if (got != want) errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// sample, noise_mean, noise_rms, zero fill
	logic [InW-1:0] s_axis_tdata;
	// first_row, row_end
	logic [1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// sample_index, row_index, dm_value, median_value, significance, zero fill
	logic [OutW-1:0] m_axis_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxBits-1:0] cfg_index;
	logic [CfgDataBits-1:0] cfg_data;

	detection_scoreboard board;
	int idle_cycles;
	int hold_off;

	median_sigma_detector_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Input and output transactions go to the scoreboard; the watchdog counts idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) board.note_sample(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) board.check_detection(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= Watchdog) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, mostly short, plus requested long hold-offs.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				hold_off--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0)
				m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
			else
				m_axis_tready <= 1'b1;
		end
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offers one sample and waits for its transaction. Valid stays high after the
	// transaction so that back-to-back samples need no second drive in one step.
	task automatic send_sample(logic [SampleBits-1:0] smp, logic [SampleBits-1:0] mn,
			logic [RmsBits-1:0] rms, logic first, logic last, bit gaps);
		int gap;
		gap = gaps ? gap_length() : 0;
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= InW'({rms, mn, smp});
		s_axis_tuser <= {last, first};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Waits until every predicted detection has left, then lets the divider drain.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// Writes one register; valid stays high until the next sample or drain.
	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
		s_axis_tvalid <= 1'b0;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		@(negedge clk);
	endtask

	// One row of noise with an optional pulse; first marks a block start.
	task automatic send_row(int len, bit first, bit gaps);
		int base, rms, pulse_at;
		logic [SampleBits-1:0] smp, mn;
		logic [RmsBits-1:0] r;
		base = int'($urandom_range(0, 4000)) - 2000;
		rms = int'($urandom_range(1, 300));
		pulse_at = int'($urandom_range(0, len));
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				smp = SampleBits'($urandom);
				mn = SampleBits'($urandom);
				r = RmsBits'($urandom);
			end else begin
				smp = SampleBits'(base + int'($urandom_range(0, 2*rms)) - rms);
				if (i >= pulse_at && i < pulse_at + 4)
					smp = SampleBits'(int'(smp) + rms * int'($urandom_range(3, 30)));
				mn = SampleBits'(base);
				r = RmsBits'(rms);
			end
			send_sample(smp, mn, r, first && i == 0, i == len - 1, gaps);
		end
	endtask

	initial begin
		board = new();
		board.reset_state();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		idle_cycles = 0;
		hold_off = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, zero rms, both modes, short rows, large DM.
		write_reg(REG_START_DM, 24'd512);
		write_reg(REG_THRESHOLD, 24'd0);
		send_sample(24'h7fffff, 24'h800000, 23'h7fffff, 1'b1, 1'b0, 0);
		send_sample(24'h800000, 24'h7fffff, 23'h000000, 1'b0, 1'b0, 0);
		send_sample(24'h7fffff, 24'h000000, 23'h000001, 1'b0, 1'b0, 0);
		send_sample(24'h7fffff, 24'h000000, 23'h000001, 1'b0, 1'b0, 0);
		send_sample(24'h7fffff, 24'h000000, 23'h000001, 1'b0, 1'b0, 0);
		send_sample(24'h000000, 24'h000000, 23'h000001, 1'b0, 1'b0, 0);
		send_sample(24'h800000, 24'h800000, 23'h7fffff, 1'b0, 1'b0, 0);
		send_sample(24'h000000, 24'h000000, 23'h000000, 1'b0, 1'b1, 0);
		send_sample(24'h000100, 24'h000000, 23'h000000, 1'b0, 1'b0, 0);
		send_sample(24'h000100, 24'h000000, 23'h000000, 1'b0, 1'b1, 0);
		drain();
		write_reg(REG_SNR_MODE, 24'd0);
		write_reg(REG_START_DM, 24'hffffff);
		write_reg(REG_DM_STEP, 24'hffff);
		send_row(6, 1, 0);
		for (int i = 0; i < 60; i++) send_row(1, 0, 0);
		send_row(7, 0, 0);
		drain();

		// The sender pauses here until every detection has arrived.
		write_reg(REG_THRESHOLD, 24'hffff);
		write_reg(REG_SNR_MODE, 24'd1);
		write_reg(REG_START_DM, 24'd0);
		write_reg(REG_DM_STEP, 24'd256);
		send_row(12, 1, 1);
		send_row(12, 0, 1);
		drain();

		// Random phases over several register settings.
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_THRESHOLD,
				phase == 0 ? 24'd0 : CfgDataBits'($urandom_range(0, 1500)));
			write_reg(REG_START_DM, CfgDataBits'($urandom_range(0, 600)));
			write_reg(REG_DM_STEP, CfgDataBits'($urandom_range(0, 300)));
			write_reg(REG_SNR_MODE, CfgDataBits'(phase[0]));
			// Long receiver stall so the block fills and stops taking samples.
			if (phase == 1) hold_off = 400;
			for (int r = 0; r < 6; r++) send_row($urandom_range(5, 20), r == 0, 1);
			drain();
		end
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
